// ===== hw/rtl/vt4_pkg.sv =====
// vt4_pkg: shared types and constants of the 4x4 vertex transform
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package vt4_pkg;

	localparam int NUM_LANES  = 4;
	localparam int COMP_W     = 32;
	localparam int COEF_W     = 16;
	localparam int ROW_W      = NUM_LANES * COEF_W;
	localparam int PROD_W     = COEF_W + COMP_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int FRAC_SHIFT = 12;
	localparam int RES_W      = 32;
	localparam int IDX_W      = 2;
	localparam int IN_DATA_W  = NUM_LANES * COMP_W;
	localparam int OUT_BITS   = NUM_LANES * RES_W + NUM_LANES;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [IDX_W-1:0] ROW_0_IDX = 2'd0;
	localparam logic [IDX_W-1:0] ROW_1_IDX = 2'd1;
	localparam logic [IDX_W-1:0] ROW_2_IDX = 2'd2;
	localparam logic [IDX_W-1:0] ROW_3_IDX = 2'd3;

	localparam logic [IDX_W-1:0] ROW_IDX [NUM_LANES] = '{
		ROW_0_IDX, ROW_1_IDX, ROW_2_IDX, ROW_3_IDX
	};

	// identity matrix, 1.0 in Q4.12 on the diagonal
	localparam logic [ROW_W-1:0] ROW_RESET [NUM_LANES] = '{
		64'h0000_0000_0000_1000,
		64'h0000_0000_1000_0000,
		64'h0000_1000_0000_0000,
		64'h1000_0000_0000_0000
	};

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t [NUM_LANES-1:0] vec_t;
	typedef logic signed [RES_W-1:0] res_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} pipe_ctl_t;

endpackage

// ===== hw/rtl/vt4_lane.sv =====
// vt4_lane: one matrix row times the vector, floor shift and saturation
// depends on vt4_pkg
`timescale 1ns / 1ps

module vt4_lane (
	input  logic                           clk,
	input  vt4_pkg::pipe_ctl_t             ctl,
	input  logic [vt4_pkg::ROW_W-1:0]      row,
	input  vt4_pkg::vec_t                  vec,
	output vt4_pkg::res_t                  res,
	output logic                           clip
);

	logic signed [vt4_pkg::PROD_W-1:0] prod_s1 [vt4_pkg::NUM_LANES];
	logic signed [vt4_pkg::SUM_W-1:0]  sum_s2;
	logic signed [vt4_pkg::SUM_W-1:0]  sum_d;
	logic [vt4_pkg::SUM_W-vt4_pkg::FRAC_SHIFT-vt4_pkg::RES_W:0] top_bits;

	// products, one multiplier per column
	always_ff @(posedge clk) begin
		for (int k = 0; k < vt4_pkg::NUM_LANES; k++) begin
			if (ctl.en_s1) begin
				prod_s1[k] <= $signed(row[k*vt4_pkg::COEF_W +: vt4_pkg::COEF_W])
					* $signed(vec[k]);
			end
		end
	end

	always_comb begin
		sum_d = '0;
		for (int k = 0; k < vt4_pkg::NUM_LANES; k++) begin
			sum_d = sum_d + vt4_pkg::SUM_W'(prod_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			sum_s2 <= sum_d;
		end
	end

	// shifted value fits when its upper bits are all copies of the sign
	assign top_bits = sum_s2[vt4_pkg::SUM_W-1 : vt4_pkg::FRAC_SHIFT+vt4_pkg::RES_W-1];

	always_comb begin
		clip = !((&top_bits) || !(|top_bits));
		if (!clip) begin
			res = sum_s2[vt4_pkg::FRAC_SHIFT +: vt4_pkg::RES_W];
		end else if (sum_s2[vt4_pkg::SUM_W-1]) begin
			res = {1'b1, {(vt4_pkg::RES_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(vt4_pkg::RES_W-1){1'b1}}};
		end
	end

endmodule

// ===== hw/rtl/vt4_out.sv =====
// vt4_out: merges the lane results into one output transaction register
// depends on vt4_pkg
`timescale 1ns / 1ps

module vt4_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                valid_in,
	input  vt4_pkg::res_t [vt4_pkg::NUM_LANES-1:0] res,
	input  logic [vt4_pkg::NUM_LANES-1:0]       clip,
	output logic                                m_tvalid,
	output logic [vt4_pkg::OUT_DATA_W-1:0]      m_tdata
);

	logic                               valid_q;
	logic [vt4_pkg::OUT_DATA_W-1:0]     data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= vt4_pkg::OUT_DATA_W'({clip, res});
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

// ===== hw/rtl/vertex_transform_4x4.sv =====
// vertex_transform_4x4: top level, matrix registers, lanes and pipeline control
// depends on vt4_pkg, vt4_lane, vt4_out
`timescale 1ns / 1ps

// Multiplies each incoming Q16.16 vector by the 4x4 Q4.12 matrix held in the
// row registers (reset to identity) and returns the product in Q16.16, floored
// and saturated, with one clip flag per component. One vector is taken every
// cycle while s_tready is high. Four row lanes of four 16x32 multipliers each
// run in parallel through a product stage and a sum stage, and an output
// register merges the lanes; each accepted vector passes through these in
// that order. Each stage moves on independently, so bubbles close up while
// the output waits. Row registers may be written only when no vector is in flight.

module vertex_transform_4x4 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [vt4_pkg::IN_DATA_W-1:0]      s_tdata,  // comp_x, comp_y, comp_z, comp_w
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [vt4_pkg::OUT_DATA_W-1:0]     m_tdata,  // res_x, res_y, res_z, res_w, saturated
	input  logic                               cfg_we,
	input  logic [vt4_pkg::IDX_W-1:0]          cfg_index,
	input  logic [vt4_pkg::ROW_W-1:0]          cfg_data
);

	logic [vt4_pkg::ROW_W-1:0]               row_q [vt4_pkg::NUM_LANES];
	logic                                    v_s1;
	logic                                    v_s2;
	logic                                    load_out;
	vt4_pkg::pipe_ctl_t                      ctl;
	vt4_pkg::vec_t                           vec;
	vt4_pkg::res_t [vt4_pkg::NUM_LANES-1:0]  res;
	logic [vt4_pkg::NUM_LANES-1:0]           clip;

	assign vec = s_tdata;

	// stall chain
	assign load_out   = !m_tvalid || m_tready;
	assign ctl.en_s2  = !v_s2 || load_out;
	assign ctl.en_s1  = !v_s1 || ctl.en_s2;
	assign s_tready   = ctl.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				v_s1 <= s_tvalid;
			end
			if (ctl.en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	for (genvar g = 0; g < vt4_pkg::NUM_LANES; g++) begin : g_lane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				row_q[g] <= vt4_pkg::ROW_RESET[g];
			end else if (cfg_we && cfg_index == vt4_pkg::ROW_IDX[g]) begin
				row_q[g] <= cfg_data;
			end
		end

		vt4_lane u_lane (
			.clk  (clk),
			.ctl  (ctl),
			.row  (row_q[g]),
			.vec  (vec),
			.res  (res[g]),
			.clip (clip[g])
		);
	end

	vt4_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_out),
		.valid_in (v_s2),
		.res      (res),
		.clip     (clip),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== hw/rtl/vt4_checker.sv =====
// vt4_checker: port-level assertions for vertex_transform_4x4, bound to the top
// depends on vt4_pkg
`timescale 1ns / 1ps

module vt4_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tready,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [vt4_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam logic [31:0] MAX_V = 32'h7fff_ffff;
	localparam logic [31:0] MIN_V = 32'h8000_0000;

	// held transaction stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transaction dropped while stalled");

	// held transaction keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	// input stalls only behind a stalled output
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled with output free");

	// a clip flag comes with a limit value
	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(!m_tdata[128] || m_tdata[31:0] == MAX_V || m_tdata[31:0] == MIN_V) &&
			(!m_tdata[129] || m_tdata[63:32] == MAX_V || m_tdata[63:32] == MIN_V) &&
			(!m_tdata[130] || m_tdata[95:64] == MAX_V || m_tdata[95:64] == MIN_V) &&
			(!m_tdata[131] || m_tdata[127:96] == MAX_V || m_tdata[127:96] == MIN_V))
		else $error("clip flag without saturated value");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[vt4_pkg::OUT_DATA_W-1:vt4_pkg::OUT_BITS] == '0)
		else $error("padding bits set");

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== sim/vertex_transform_4x4_tb.sv =====
`timescale 1ns / 1ps
// vertex_transform_4x4_tb: self-checking bench for the 4x4 Q4.12 x Q16.16 vertex transform
// streams vectors under several matrices with bursty input and stalling output, predicts
// each floored, saturated product in the bench; depends on vt4_pkg and vertex_transform_4x4

module vertex_transform_4x4_tb;

	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     RANDOM_PHASES  = 10;
	localparam int     PHASE_VECTORS  = 150;
	localparam int     REPORT_LIMIT   = 10;
	localparam longint RES_MAX        = 64'sd2147483647;
	localparam longint RES_MIN        = -64'sd2147483648;

	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef logic [vt4_pkg::ROW_W-1:0] matrix_t [vt4_pkg::NUM_LANES];

	typedef struct packed {
		logic [vt4_pkg::OUT_DATA_W-vt4_pkg::OUT_BITS-1:0] pad;
		logic [vt4_pkg::NUM_LANES-1:0]                    sat;
		vt4_pkg::res_t [vt4_pkg::NUM_LANES-1:0]           res;
	} xform_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [vt4_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [vt4_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           cfg_we    = 1'b0;
	logic [vt4_pkg::IDX_W-1:0]      cfg_index = '0;
	logic [vt4_pkg::ROW_W-1:0]      cfg_data  = '0;

	matrix_t  coef_rows;
	xform_t   pending_xforms [$];
	xform_t   mon_got;
	xform_t   mon_want;
	int       mon_lane;
	string    lane_names [vt4_pkg::NUM_LANES] = '{"res_x", "res_y", "res_z", "res_w"};
	int       mismatches   = 0;
	int       vectors_in   = 0;
	int       results_out  = 0;
	int       sat_lanes    = 0;
	int       matrix_loads = 0;
	int       quiet_cycles = 0;
	int       burst_left   = 0;
	rx_mode_t rx_mode      = RX_ALWAYS;
	int       rx_left      = 0;
	int       rx_tick      = 0;

	vertex_transform_4x4 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// M*v per lane: exact sum, floor shift by 12, clip to 32 bits
	function automatic xform_t transform_vertex(input vt4_pkg::vec_t v);
		xform_t t;
		longint acc;
		longint q;
		int     r;
		int     k;
		t = '0;
		for (r = 0; r < vt4_pkg::NUM_LANES; r++) begin
			acc = 0;
			for (k = 0; k < vt4_pkg::NUM_LANES; k++)
				acc += longint'($signed(coef_rows[r][vt4_pkg::COEF_W*k +: vt4_pkg::COEF_W]))
					* longint'(v[k]);
			q = acc >>> vt4_pkg::FRAC_SHIFT;
			if (q > RES_MAX) begin
				q = RES_MAX;
				t.sat[r] = 1'b1;
			end else if (q < RES_MIN) begin
				q = RES_MIN;
				t.sat[r] = 1'b1;
			end
			t.res[r] = vt4_pkg::res_t'(q);
		end
		return t;
	endfunction

	function automatic vt4_pkg::vec_t make_vec(input vt4_pkg::comp_t x,
			input vt4_pkg::comp_t y, input vt4_pkg::comp_t z, input vt4_pkg::comp_t w);
		vt4_pkg::vec_t v;
		v[0] = x;
		v[1] = y;
		v[2] = z;
		v[3] = w;
		return v;
	endfunction

	function automatic vt4_pkg::comp_t rand_comp();
		case ($urandom_range(0, 4))
			0: return vt4_pkg::comp_t'($urandom);
			1: return vt4_pkg::comp_t'($signed($urandom) >>> $urandom_range(8, 24));
			2: return vt4_pkg::comp_t'($signed($urandom) >>> $urandom_range(1, 7));
			3: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					2: return 32'sh0000_0000;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			default: return vt4_pkg::comp_t'($signed($urandom) >>> 16);
		endcase
	endfunction

	function automatic logic [vt4_pkg::COEF_W-1:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return vt4_pkg::COEF_W'($urandom);
			1: return vt4_pkg::COEF_W'(4096 + $urandom_range(0, 511) - 256);
			2: return vt4_pkg::COEF_W'($signed(vt4_pkg::COEF_W'($urandom))
				>>> $urandom_range(2, 12));
			3: begin
				case ($urandom_range(0, 4))
					0: return 16'h7fff;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'hffff;
					default: return 16'h0001;
				endcase
			end
			default: return 16'h0000;
		endcase
	endfunction

	function automatic matrix_t diag_matrix(input logic [vt4_pkg::COEF_W-1:0] d);
		matrix_t m;
		int r;
		for (r = 0; r < vt4_pkg::NUM_LANES; r++) begin
			m[r] = '0;
			m[r][vt4_pkg::COEF_W*r +: vt4_pkg::COEF_W] = d;
		end
		return m;
	endfunction

	function automatic matrix_t uniform_matrix(input logic [vt4_pkg::COEF_W-1:0] c);
		matrix_t m;
		int r;
		for (r = 0; r < vt4_pkg::NUM_LANES; r++)
			m[r] = {vt4_pkg::NUM_LANES{c}};
		return m;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] have);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t mismatch on %s: expected %h, got %h", $time, what, want, have);
	endtask

	// one vector per call; opens a new burst after a random gap when the last one ran out
	task automatic send_vector(input vt4_pkg::vec_t v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_xforms.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_matrix(input matrix_t m);
		int r;
		wait_idle();
		for (r = 0; r < vt4_pkg::NUM_LANES; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= vt4_pkg::ROW_IDX[r];
			cfg_data  <= m[r];
			@(posedge clk);
			coef_rows[r] = m[r];
		end
		cfg_we <= 1'b0;
		matrix_loads++;
	endtask

	task automatic test_identity_reset();
		send_vector(make_vec(32'sd0, 32'sd0, 32'sd0, 32'sd0));
		send_vector(make_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		send_vector(make_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		send_vector(make_vec(32'sd1, -32'sd1, 32'sd2, -32'sd2));
		send_vector(make_vec(32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0));
	endtask

	task automatic test_saturation();
		// 2.0 on the diagonal: just past and just inside both limits
		load_matrix(diag_matrix(16'h2000));
		send_vector(make_vec(32'sh4000_0000, 32'sh3fff_ffff, 32'shc000_0000, 32'shbfff_ffff));
		send_vector(make_vec(32'shbfff_ffff, 32'shc000_0000, 32'sh3fff_ffff, 32'sh4000_0000));
		load_matrix(uniform_matrix(16'h7fff));
		send_vector(make_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		send_vector(make_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		send_vector(make_vec(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, -32'sd1));
		load_matrix(uniform_matrix(16'h8000));
		send_vector(make_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		send_vector(make_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
	endtask

	task automatic test_negative_rounding();
		// smallest coefficient so the floor shift shows on every lane
		load_matrix(diag_matrix(16'h0001));
		send_vector(make_vec(-32'sd1, 32'sd1, -32'sd4096, 32'sd4095));
		send_vector(make_vec(-32'sd4097, 32'sd4096, 32'sh8000_0000, 32'sh7fff_ffff));
		load_matrix(uniform_matrix(16'hffff));
		send_vector(make_vec(32'sd1, 32'sd0, 32'sd0, 32'sd0));
		send_vector(make_vec(-32'sd1, 32'sd0, 32'sd0, 32'sd0));
	endtask

	task automatic test_random_stream();
		matrix_t m;
		int p;
		int n;
		int r;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			for (r = 0; r < vt4_pkg::NUM_LANES; r++)
				m[r] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
			load_matrix(m);
			for (n = 0; n < PHASE_VECTORS; n++) begin
				// in every third phase, hold off mid-phase until the pipeline has emptied
				if (n == PHASE_VECTORS / 2 && p % 3 == 1)
					wait_idle();
				send_vector(make_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
			end
		end
	endtask

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 150);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_ALWAYS:   m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   m_tready <= ($urandom_range(0, 4) == 0);
			RX_PERIODIC: m_tready <= ((rx_tick % 11) >= 7);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pending_xforms.push_back(transform_vertex(s_tdata));
				vectors_in++;
			end
			if (m_tvalid && m_tready) begin
				mon_got = m_tdata;
				results_out++;
				if (pending_xforms.size() == 0) begin
					report_mismatch("result with no vector pending", '0, mon_got.res[0]);
				end else begin
					mon_want = pending_xforms.pop_front();
					sat_lanes += $countones(mon_want.sat);
					for (mon_lane = 0; mon_lane < vt4_pkg::NUM_LANES; mon_lane++)
						if (mon_got.res[mon_lane] !== mon_want.res[mon_lane])
							report_mismatch(lane_names[mon_lane], mon_want.res[mon_lane],
								mon_got.res[mon_lane]);
					if (mon_got.sat !== mon_want.sat)
						report_mismatch("saturated", 32'(mon_want.sat), 32'(mon_got.sat));
					if (mon_got.pad !== '0)
						report_mismatch("padding", '0, 32'(mon_got.pad));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no transaction for %0d cycles, %0d results pending",
						quiet_cycles, pending_xforms.size());
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		coef_rows = vt4_pkg::ROW_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_identity_reset();
		test_saturation();
		test_negative_rounding();
		test_random_stream();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("covered %0d vectors under %0d matrix settings, %0d lanes clipped",
			vectors_in, matrix_loads + 1, sat_lanes);
		$display("checked %0d results, %0d mismatches", results_out, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
